[rtl/core/lgc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgc_pkg
// Shared types and constants for the linear gradient colormap.
// ----------------------------------------------------------------------------
package lgc_pkg;

    // Q0.16 fraction: 16 quotient bits, 1.0 needs a 17th bit
    localparam int T_BITS      = 16;
    localparam int T_W         = T_BITS + 1;
    localparam int NUM_W       = 32;    // numerator carried to the divider (< den for CLS_DIV)
    localparam int COLOR_W     = 16;    // Q2.14 component
    localparam int NUM_LANES   = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_BITS;

    typedef enum logic [1:0] {
        CFG_RANGE_LO    = 2'd0,
        CFG_RANGE_HI    = 2'd1,
        CFG_START_COLOR = 2'd2,
        CFG_END_COLOR   = 2'd3
    } cfg_reg_t;

    // how the back end derives t for a pixel
    typedef enum logic [1:0] {
        CLS_DIV  = 2'd0,    // 0 < num < den: divide
        CLS_ZERO = 2'd1,    // num <= 0
        CLS_ONE  = 2'd2,    // num >= den
        CLS_ERR  = 2'd3     // empty or inverted range
    } cls_t;

    typedef struct packed {
        cls_t              cls;
        logic [NUM_W-1:0]  num;
        logic              last;
    } qent_t;

    typedef struct packed {
        logic  valid;
        qent_t ent;
    } q_push_t;

    typedef struct packed {
        logic  valid;
        qent_t ent;
    } q_head_t;

    typedef struct packed {
        logic [NUM_LANES-1:0][7:0] bytes;
        logic                      range_error;
        logic                      tile_end;
    } pix_t;

endpackage

[rtl/core/lgc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgc_front
// Accepts samples and classifies them against the configured signal range.
// ----------------------------------------------------------------------------
module lgc_front #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           in_valid,
    input  logic                           queue_full,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           last_in_tile,
    input  logic signed [31:0]             range_lo,
    input  logic signed [32:0]             den,
    output lgc_pkg::q_push_t               push
);

    localparam int EXT_W = ((SAMPLE_WIDTH > 32) ? SAMPLE_WIDTH : 32) + 1;

    logic signed [EXT_W-1:0] num;
    logic signed [EXT_W-1:0] den_ext;
    logic                    den_bad;
    logic                    num_le0;
    logic                    num_ge;

    assign num     = EXT_W'(sample) - EXT_W'(range_lo);
    assign den_ext = EXT_W'(den);
    assign den_bad = den[32] || (den == 33'sd0);
    assign num_le0 = num[EXT_W-1] || (num == '0);
    assign num_ge  = (num >= den_ext);

    always_comb
    begin
        push.valid    = in_valid && !queue_full;
        push.ent.num  = num[lgc_pkg::NUM_W-1:0];
        push.ent.last = last_in_tile;
        if (den_bad)
        begin
            push.ent.cls = lgc_pkg::CLS_ERR;
        end
        else if (num_le0)
        begin
            push.ent.cls = lgc_pkg::CLS_ZERO;
        end
        else if (num_ge)
        begin
            push.ent.cls = lgc_pkg::CLS_ONE;
        end
        else
        begin
            push.ent.cls = lgc_pkg::CLS_DIV;
        end
    end

endmodule

[rtl/core/lgc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgc_queue
// Short FIFO between the classifier and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module lgc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  lgc_pkg::q_push_t push,
    input  logic             pop,
    output logic             full,
    output lgc_pkg::q_head_t head
);

    localparam int CNT_W = lgc_pkg::QPTR_W + 1;

    lgc_pkg::qent_t              mem [lgc_pkg::QUEUE_DEPTH];
    logic [lgc_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [lgc_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        do_push;
    logic                        do_pop;

    assign full       = (count_reg == CNT_W'(lgc_pkg::QUEUE_DEPTH));
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.ent   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + lgc_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + lgc_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.ent;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(lgc_pkg::QUEUE_DEPTH))
        else $error("queue count past depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push.valid)
        else $error("front pushed into a full queue");

endmodule

[rtl/core/lgc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgc_back
// Restoring divider (one quotient bit per stage), per-component
// interpolation multiply, clamp/scale/round, and the output register.
// ----------------------------------------------------------------------------
module lgc_back #(
    parameter int COMPONENTS = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  lgc_pkg::q_head_t head,
    output logic             pop,
    input  logic [31:0]      den,
    input  logic [63:0]      start_color,
    input  logic [63:0]      end_color,
    output logic             out_valid,
    input  logic             out_stall,
    output lgc_pkg::pix_t    pix
);

    localparam int STEPS  = lgc_pkg::T_BITS;
    localparam int NW     = lgc_pkg::NUM_W;
    localparam int CW     = lgc_pkg::COLOR_W;
    localparam int PROD_W = 35;
    localparam int V_W    = 36;
    localparam int P_W    = V_W + 8;

    logic adv;

    // divider stage registers
    logic [NW-1:0]     rem_reg  [STEPS];
    logic [STEPS-1:0]  q_reg    [STEPS];
    lgc_pkg::cls_t     cls_reg  [STEPS];
    logic              last_reg [STEPS];
    logic              vld_reg  [STEPS];

    // multiply stage
    logic signed [PROD_W-1:0] prod_reg [COMPONENTS];
    logic                     m_vld_reg;
    logic                     m_err_reg;
    logic                     m_last_reg;

    // output register
    logic                     out_valid_reg;
    lgc_pkg::pix_t            pix_reg;
    lgc_pkg::pix_t            pix_next;
    logic [lgc_pkg::T_W-1:0]  t_next;

    // whole pipeline moves together; only a stalled full output holds it
    assign adv       = !out_valid_reg || !out_stall;
    assign pop       = adv && head.valid;
    assign out_valid = out_valid_reg;
    assign pix       = pix_reg;

    genvar s;
    generate
        for (s = 0; s < STEPS; s++)
        begin : g_div
            logic [NW-1:0]    rem_in;
            logic [STEPS-1:0] q_in;
            lgc_pkg::cls_t    cls_in;
            logic             last_in;
            logic             vld_in;
            logic [NW:0]      shifted;
            logic [NW:0]      diff;
            logic             ge;

            if (s == 0)
            begin : g_first
                assign rem_in  = head.ent.num;
                assign q_in    = '0;
                assign cls_in  = head.ent.cls;
                assign last_in = head.ent.last;
                assign vld_in  = head.valid;
            end
            else
            begin : g_next
                assign rem_in  = rem_reg[s-1];
                assign q_in    = q_reg[s-1];
                assign cls_in  = cls_reg[s-1];
                assign last_in = last_reg[s-1];
                assign vld_in  = vld_reg[s-1];
            end

            assign shifted = {rem_in, 1'b0};
            assign diff    = shifted - {1'b0, den};
            assign ge      = (shifted >= {1'b0, den});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else if (adv)
                begin
                    vld_reg[s] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[s]  <= ge ? diff[NW-1:0] : shifted[NW-1:0];
                    q_reg[s]    <= {q_in[STEPS-2:0], ge};
                    cls_reg[s]  <= cls_in;
                    last_reg[s] <= last_in;
                end
            end
        end
    endgenerate

    always_comb
    begin
        case (cls_reg[STEPS-1])
            lgc_pkg::CLS_DIV:  t_next = {1'b0, q_reg[STEPS-1]};
            lgc_pkg::CLS_ONE:  t_next = lgc_pkg::T_ONE;
            default:           t_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_vld_reg     <= vld_reg[STEPS-1];
            out_valid_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_err_reg  <= (cls_reg[STEPS-1] == lgc_pkg::CLS_ERR);
            m_last_reg <= last_reg[STEPS-1];
            pix_reg    <= pix_next;
        end
    end

    genvar c;
    generate
        for (c = 0; c < lgc_pkg::NUM_LANES; c++)
        begin : g_lane
            if (c < COMPONENTS)
            begin : g_used
                logic signed [CW-1:0]     a;
                logic signed [CW-1:0]     b;
                logic signed [CW:0]       d;
                logic signed [V_W-1:0]    v;
                logic [P_W-1:0]           p;
                logic [P_W-1:0]           rsum;
                logic [P_W-31:0]          r;

                assign a = $signed(start_color[c*CW +: CW]);
                assign b = $signed(end_color[c*CW +: CW]);
                assign d = (CW+1)'(b) - (CW+1)'(a);

                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        prod_reg[c] <= PROD_W'(d) * PROD_W'($signed({1'b0, t_next}));
                    end
                end

                // v in units of 2^-30; byte = round-half-up of v * 255 / 2^30
                assign v    = V_W'($signed({a, 16'h0000})) + V_W'(prod_reg[c]);
                assign p    = {v[V_W-1:0], 8'h00} - {8'h00, v[V_W-1:0]};
                assign rsum = p + (P_W'(1) << 29);
                assign r    = rsum[P_W-1:30];

                always_comb
                begin
                    if (m_err_reg || v[V_W-1] || (v == '0))
                    begin
                        pix_next.bytes[c] = 8'h00;
                    end
                    else if (r > (P_W-30)'(255))
                    begin
                        pix_next.bytes[c] = 8'hFF;
                    end
                    else
                    begin
                        pix_next.bytes[c] = r[7:0];
                    end
                end
            end
            else
            begin : g_unused
                assign pix_next.bytes[c] = 8'h00;
            end
        end
    endgenerate

    assign pix_next.range_error = m_err_reg;
    assign pix_next.tile_end    = m_last_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && pix_reg.range_error) |-> (pix_reg.bytes == '0))
        else $error("range error beat carries nonzero color");

    a_hold_m: assert property (@(posedge clk) disable iff (!rst_n)
        (m_vld_reg && !adv) |=> m_vld_reg)
        else $error("pipeline dropped a pixel while output stalled");

endmodule

[rtl/core/linear_gradient_colormap_rgba.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_gradient_colormap_rgba
// Maps a Q16.16 sample onto a linear RGBA gradient between two colors.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------
//  in       | in_valid / in_stall      | sample, last_in_tile
//  out      | out_valid / out_stall    | red, green, blue, alpha,
//           |                          | range_error, tile_end
//  cfg      | cfg_write                | cfg_index, cfg_data
//
//  One pixel per clock sustained while the output is not stalled. An input
//  beat passes through the queue register, 16 restoring-divider stages (one
//  quotient bit each), one multiply stage and the output register.
//  Reset clears the queue and pipeline valids and loads the default range
//  and colors. A stall on a valid output freezes the pipeline; the 4-entry
//  queue absorbs input until full, then in_stall rises.
// ----------------------------------------------------------------------------
module linear_gradient_colormap_rgba #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int COMPONENTS   = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [1:0]                     cfg_index,
    input  logic [63:0]                    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           last_in_tile,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     red,
    output logic [7:0]                     green,
    output logic [7:0]                     blue,
    output logic [7:0]                     alpha,
    output logic                           range_error,
    output logic                           tile_end
);

    logic signed [31:0] range_lo_reg;
    logic signed [31:0] range_hi_reg;
    logic [63:0]        start_color_reg;
    logic [63:0]        end_color_reg;
    logic signed [32:0] den;
    lgc_pkg::q_push_t   push;
    lgc_pkg::q_head_t   head;
    logic               pop;
    logic               full;
    lgc_pkg::pix_t      pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_lo_reg    <= 32'sd0;
            range_hi_reg    <= 32'sd65536;
            start_color_reg <= 64'h0;
            end_color_reg   <= 64'h4000_4000_4000_4000;
        end
        else if (cfg_write)
        begin
            case (lgc_pkg::cfg_reg_t'(cfg_index))
                lgc_pkg::CFG_RANGE_LO:    range_lo_reg    <= $signed(cfg_data[31:0]);
                lgc_pkg::CFG_RANGE_HI:    range_hi_reg    <= $signed(cfg_data[31:0]);
                lgc_pkg::CFG_START_COLOR: start_color_reg <= cfg_data;
                lgc_pkg::CFG_END_COLOR:   end_color_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign den = 33'(range_hi_reg) - 33'(range_lo_reg);

    lgc_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .in_valid     (in_valid),
        .queue_full   (full),
        .sample       (sample),
        .last_in_tile (last_in_tile),
        .range_lo     (range_lo_reg),
        .den          (den),
        .push         (push)
    );

    lgc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (full),
        .head  (head)
    );

    lgc_back #(
        .COMPONENTS (COMPONENTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .den         (den[31:0]),
        .start_color (start_color_reg),
        .end_color   (end_color_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pix         (pix)
    );

    assign in_stall    = full;
    assign red         = pix.bytes[0];
    assign green       = pix.bytes[1];
    assign blue        = pix.bytes[2];
    assign alpha       = pix.bytes[3];
    assign range_error = pix.range_error;
    assign tile_end    = pix.tile_end;

endmodule

[tb/colormap_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colormap_checker
// Watches the config port and both pixel channels of the colormap. Every
// input beat is mapped to its expected RGBA pixel and queued. Each output
// beat is compared field by field with the oldest queued pixel.
// ----------------------------------------------------------------------------
module colormap_checker #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int COMPONENTS   = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [1:0]                     cfg_index,
    input  logic [63:0]                    cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           last_in_tile,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [7:0]                     red,
    input  logic [7:0]                     green,
    input  logic [7:0]                     blue,
    input  logic [7:0]                     alpha,
    input  logic                           range_error,
    input  logic                           tile_end,
    output int                             pending,
    output int                             mismatches
);

    localparam longint HALF_LSB = 64'sd1 <<< 29;

    logic signed [31:0] range_lo;
    logic signed [31:0] range_hi;
    logic [63:0]        color_from;
    logic [63:0]        color_to;

    lgc_pkg::pix_t expected_pixels[$];

    // Normalize the sample into Q0.16, then interpolate and round each lane.
    function automatic lgc_pkg::pix_t map_pixel(logic signed [SAMPLE_WIDTH-1:0] s,
                                                logic last);
        longint        span;
        longint        offset;
        longint        frac;
        longint        from_c;
        longint        to_c;
        longint        mix;
        longint        level;
        lgc_pkg::pix_t px;
        px          = '0;
        px.tile_end = last;
        span        = longint'(range_hi) - longint'(range_lo);
        if (span <= 0)
        begin
            px.range_error = 1'b1;
            return px;
        end
        offset = longint'(s) - longint'(range_lo);
        if (offset <= 0)
            frac = 0;
        else if (offset >= span)
            frac = 65536;
        else
            frac = (offset <<< 16) / span;
        for (int c = 0; c < lgc_pkg::NUM_LANES; c++)
        begin
            if (c < COMPONENTS)
            begin
                from_c = longint'($signed(color_from[16*c +: 16]));
                to_c   = longint'($signed(color_to[16*c +: 16]));
                mix    = from_c * 65536 + (to_c - from_c) * frac;
                if (mix > 0)
                begin
                    level = (mix * 255 + HALF_LSB) >>> 30;
                    if (level > 255)
                        level = 255;
                    px.bytes[c] = level[7:0];
                end
            end
        end
        return px;
    endfunction

    initial
    begin
        pending    = 0;
        mismatches = 0;
        range_lo   = 32'sd0;
        range_hi   = 32'sd65536;
        color_from = 64'h0;
        color_to   = 64'h4000_4000_4000_4000;
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        lgc_pkg::pix_t seen;
        lgc_pkg::pix_t want;
        if (!rst_n)
        begin
            range_lo   = 32'sd0;
            range_hi   = 32'sd65536;
            color_from = 64'h0;
            color_to   = 64'h4000_4000_4000_4000;
            expected_pixels.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (lgc_pkg::cfg_reg_t'(cfg_index))
                    lgc_pkg::CFG_RANGE_LO:    range_lo   = cfg_data[31:0];
                    lgc_pkg::CFG_RANGE_HI:    range_hi   = cfg_data[31:0];
                    lgc_pkg::CFG_START_COLOR: color_from = cfg_data;
                    lgc_pkg::CFG_END_COLOR:   color_to   = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                seen.bytes       = {alpha, blue, green, red};
                seen.range_error = range_error;
                seen.tile_end    = tile_end;
                if (expected_pixels.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected output beat: r=%0d g=%0d b=%0d a=%0d",
                                 red, green, blue, alpha,
                                 " err=%0b end=%0b", range_error, tile_end);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (seen.bytes[0] !== want.bytes[0] || seen.bytes[1] !== want.bytes[1] ||
                        seen.bytes[2] !== want.bytes[2] || seen.bytes[3] !== want.bytes[3] ||
                        seen.range_error !== want.range_error ||
                        seen.tile_end !== want.tile_end)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("pixel mismatch at %0t: exp r=%0d g=%0d b=%0d a=%0d",
                                     $realtime, want.bytes[0], want.bytes[1],
                                     want.bytes[2], want.bytes[3],
                                     " err=%0b end=%0b", want.range_error, want.tile_end);
                            $display("    got r=%0d g=%0d b=%0d a=%0d err=%0b end=%0b",
                                     seen.bytes[0], seen.bytes[1], seen.bytes[2],
                                     seen.bytes[3], seen.range_error, seen.tile_end);
                        end
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_pixels.insert(expected_pixels.size(),
                                       map_pixel(sample, last_in_tile));
        end
        pending = expected_pixels.size();
    end

endmodule

[tb/linear_gradient_colormap_rgba_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_gradient_colormap_rgba_test
// Drives samples through the colormap under a sequence of ranges and color
// pairs (defaults, extremes, empty and inverted ranges, out-of-range colors,
// then random ones) with random gaps and output stalls and one long output
// hold-off. A separate checker predicts and compares every pixel.
// ----------------------------------------------------------------------------
module linear_gradient_colormap_rgba_test;

    localparam int SAMPLE_W     = 32;
    localparam int LANES        = 4;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 110;
    localparam int QUIET_FROM   = PHASES * PHASE_ITEMS - 150;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 120;
    localparam int STUCK_LIMIT  = 3000;

    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_write;
    logic [1:0]                 cfg_index;
    logic [63:0]                cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_in_tile;
    logic                       out_valid;
    logic                       out_stall;
    logic [7:0]                 red;
    logic [7:0]                 green;
    logic [7:0]                 blue;
    logic [7:0]                 alpha;
    logic                       range_error;
    logic                       tile_end;

    int pending;
    int mismatches;
    int pixels_sent = 0;
    int tx_free     = 0;
    int stuck       = 0;
    bit quiet       = 1'b0;

    always #6 clk = ~clk;

    linear_gradient_colormap_rgba #(
        .SAMPLE_WIDTH(SAMPLE_W),
        .COMPONENTS  (LANES)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .last_in_tile(last_in_tile),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .range_error (range_error),
        .tile_end    (tile_end)
    );

    colormap_checker #(
        .SAMPLE_WIDTH(SAMPLE_W),
        .COMPONENTS  (LANES)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .last_in_tile(last_in_tile),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .range_error (range_error),
        .tile_end    (tile_end),
        .pending     (pending),
        .mismatches  (mismatches)
    );

    // watchdog: any beat on either channel counts as progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck <= 0;
            else
                stuck <= stuck + 1;
            if (stuck >= STUCK_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // output stall bursts, one long hold-off to back the block up
    initial
    begin : rx_stall_gen
        int  calm;
        bit  held_off;
        calm      = 0;
        held_off  = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && pixels_sent >= HOLD_AT)
            begin
                held_off  = 1'b1;
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall = 1'b0;
            end
            else if (calm > 0)
                calm--;
            else if (!quiet)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                out_stall = 1'b0;
                calm = $urandom_range(0, 30);
            end
        end
    end

    task automatic send_pixel(input logic signed [SAMPLE_W-1:0] s, input logic last);
        @(negedge clk);
        if (!quiet && tx_free == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            tx_free = $urandom_range(0, 24);
        end
        else if (tx_free > 0)
            tx_free--;
        in_valid     = 1'b1;
        sample       = s;
        last_in_tile = last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pixels_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input lgc_pkg::cfg_reg_t idx, input logic [63:0] value);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
    endtask

    // only the low 32 bits of a range register matter; upper bits get noise
    task automatic load_gradient(input logic [31:0] lo, input logic [31:0] hi,
                                 input logic [63:0] from_c, input logic [63:0] to_c);
        wait_drained();
        write_reg(lgc_pkg::CFG_RANGE_LO, {$urandom, lo});
        write_reg(lgc_pkg::CFG_RANGE_HI, {$urandom, hi});
        write_reg(lgc_pkg::CFG_START_COLOR, from_c);
        write_reg(lgc_pkg::CFG_END_COLOR, to_c);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // mostly in-gamut components, some arbitrary Q2.14 patterns
    function automatic logic [63:0] random_color();
        logic [63:0] col;
        for (int c = 0; c < 4; c++)
            col[16*c +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(0, 16'h4000));
        return col;
    endfunction

    initial
    begin : stimulus
        longint     lo;
        longint     hi;
        longint     span;
        longint     pick;
        bit [63:0]  r64;
        cfg_write    = 1'b0;
        cfg_index    = lgc_pkg::CFG_RANGE_LO;
        cfg_data     = 64'h0;
        in_valid     = 1'b0;
        sample       = '0;
        last_in_tile = 1'b0;
        rst_n        = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // reset gradient: black to white over [0, 1.0]
        send_pixel(32'sd0, 1'b0);
        send_pixel(32'sd65536, 1'b1);
        send_pixel(32'sd32768, 1'b0);
        send_pixel(-32'sd1, 1'b0);
        send_pixel(S_MAX, 1'b1);
        send_pixel(S_MIN, 1'b0);
        send_pixel(32'sd1, 1'b1);

        // widest range
        load_gradient(S_MIN, S_MAX, 64'h0, 64'h4000_4000_4000_4000);
        send_pixel(S_MIN, 1'b0);
        send_pixel(S_MAX, 1'b1);
        send_pixel(32'sd0, 1'b0);
        send_pixel(-32'sd1, 1'b1);

        // empty range
        load_gradient(32'sd5, 32'sd5, 64'h1234_4000_0FFF_2000, 64'h4000_0000_3000_1000);
        send_pixel(32'sd5, 1'b1);
        send_pixel(-32'sd3, 1'b0);

        // inverted ranges
        load_gradient(32'sd65536, -32'sd65536, 64'h0, 64'h4000_4000_4000_4000);
        send_pixel(32'sd0, 1'b0);
        load_gradient(S_MAX, S_MIN, 64'h0, 64'h4000_4000_4000_4000);
        send_pixel(S_MAX, 1'b1);

        // colors outside [0,1]
        load_gradient(-32'sd65536, 32'sd65536, 64'h8000_7FFF_C000_0000,
                      64'h7FFF_8000_6000_FFFF);
        send_pixel(-32'sd65536, 1'b0);
        send_pixel(32'sd0, 1'b0);
        send_pixel(32'sd32768, 1'b1);
        send_pixel(32'sd65536, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    lo = S_MIN;
                    hi = S_MAX;
                end
                1:
                begin
                    lo = longint'($signed($urandom));
                    hi = lo - $urandom_range(0, 3);
                    if (hi < S_MIN)
                        hi = S_MIN;
                end
                2:
                begin
                    lo = longint'($signed($urandom)) >>> 2;
                    hi = lo + $urandom_range(1, 4);
                end
                default:
                begin
                    lo = longint'($signed($urandom)) >>> $urandom_range(1, 16);
                    hi = lo + (longint'($urandom) >> $urandom_range(0, 24)) + 1;
                    if (hi > S_MAX)
                        hi = S_MAX;
                end
            endcase
            load_gradient(32'(lo), 32'(hi), random_color(), random_color());
            span = hi - lo;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                quiet = (p * PHASE_ITEMS + i >= QUIET_FROM);
                if (span <= 0 || $urandom_range(0, 7) == 0)
                    pick = longint'($signed($urandom));
                else
                begin
                    case ($urandom_range(0, 15))
                        0:       pick = lo;
                        1:       pick = hi;
                        2:       pick = lo - 1;
                        3:       pick = hi + 1;
                        default:
                        begin
                            r64  = {$urandom, $urandom};
                            pick = lo - span / 8 + longint'(r64 % 64'(span + span / 4 + 1));
                        end
                    endcase
                end
                send_pixel(32'(pick), $urandom_range(0, 3) == 0);
            end
        end

        wait_drained();
        repeat (30) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
